// File: hdl/double_scale_by_power_of_two_top_defines.svh
// ------------------------------------------------------------------------
// double_scale_by_power_of_two_top_defines.svh
// Assertion macros for the power-of-two scaling pipeline.
// ------------------------------------------------------------------------
`ifndef DOUBLE_SCALE_BY_POWER_OF_TWO_TOP_DEFINES_SVH
`define DOUBLE_SCALE_BY_POWER_OF_TWO_TOP_DEFINES_SVH

// Same-cycle implication.
`define DBLSCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DBLSCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dblscl_pkg.sv
// ------------------------------------------------------------------------
// dblscl_pkg
// Types, constants and helpers for the binary64 power-of-two scaler.
// ------------------------------------------------------------------------
package dblscl_pkg;

  localparam int unsigned NumStages = 5;

  localparam logic signed [13:0] ShiftSat  = 14'sd4096;
  localparam logic signed [13:0] StepUp    = 14'sd1023;
  localparam logic signed [13:0] StepDown  = -14'sd1022;
  localparam logic [10:0]        ExpMax    = 11'h7FF;
  localparam int unsigned        QuietBit  = 51;
  localparam logic signed [12:0] ExpInf    = 13'sd2047;
  localparam logic signed [12:0] ShiftZero = 13'sd60;

  // One item in flight between scaling steps.
  typedef struct packed {
    logic [63:0]        bits;
    logic signed [13:0] shift;  // remaining shift, saturated
  } item_t;

  // Normalized operand plus this step's exponent offset.
  typedef struct packed {
    logic               pass;   // NaN, infinity or zero: bits go out as is, a NaN made quiet
    logic [63:0]        bits;
    logic signed [12:0] expo;
    logic [52:0]        mant;   // hidden bit at [52]
    logic signed [12:0] k;
    logic signed [13:0] shift;
  } nrm_t;

  // Leading zeros of a 53-bit mantissa (nonzero input).
  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] cnt;
    logic       found;
    cnt   = 6'd0;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) begin
          found = 1'b1;
        end else begin
          cnt = cnt + 6'd1;
        end
      end
    end
    return cnt;
  endfunction

endpackage

// File: hdl/dblscl_norm.sv
// ------------------------------------------------------------------------
// dblscl_norm
// Classifies and normalizes the operand, picks this step's exponent offset.
// ------------------------------------------------------------------------
module dblscl_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  dblscl_pkg::item_t    item_i,
  output logic                 valid_o,
  output dblscl_pkg::nrm_t     nrm_o
);
  import dblscl_pkg::*;

  logic [10:0] efield;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic        valid_q;
  nrm_t        nrm_d, nrm_q;

  assign efield = item_i.bits[62:52];
  assign frac   = item_i.bits[51:0];
  assign lz     = lzc53({1'b0, frac});

  always_comb begin
    nrm_d      = '0;
    nrm_d.bits = item_i.bits;
    nrm_d.pass = (efield == ExpMax) || ((efield == 11'd0) && (frac == 52'd0));
    if ((efield == ExpMax) && (frac != 52'd0)) begin
      nrm_d.bits[QuietBit] = 1'b1;
    end
    if (efield == 11'd0) begin
      nrm_d.mant = {1'b0, frac} << lz;
      nrm_d.expo = 13'sd1 - $signed({7'd0, lz});
    end else begin
      nrm_d.mant = {1'b1, frac};
      nrm_d.expo = $signed({2'b00, efield});
    end
    if (item_i.shift > StepUp) begin
      nrm_d.k     = StepUp[12:0];
      nrm_d.shift = item_i.shift - StepUp;
    end else if (item_i.shift < StepDown) begin
      nrm_d.k     = StepDown[12:0];
      nrm_d.shift = item_i.shift - StepDown;
    end else begin
      nrm_d.k     = item_i.shift[12:0];
      nrm_d.shift = 14'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_q <= nrm_d;
    end
  end

  assign valid_o = valid_q;
  assign nrm_o   = nrm_q;

endmodule

// File: hdl/dblscl_round.sv
// ------------------------------------------------------------------------
// dblscl_round
// Applies the exponent offset, handles overflow and rounds subnormals.
// ------------------------------------------------------------------------
module dblscl_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  dblscl_pkg::nrm_t     nrm_i,
  output logic                 valid_o,
  output dblscl_pkg::item_t    item_o
);
  import dblscl_pkg::*;

  logic signed [12:0] et;
  logic signed [12:0] sw;
  logic [5:0]         sh;
  logic [52:0]        q, qr, rtmp, mask;
  logic               rb, sticky, sgn;
  logic               valid_q;
  item_t              item_d, item_q;

  assign sgn    = nrm_i.bits[63];
  assign et     = nrm_i.expo + nrm_i.k;
  assign sw     = 13'sd1 - et;
  assign sh     = sw[5:0];
  assign q      = nrm_i.mant >> sh;
  assign rtmp   = nrm_i.mant >> (sh - 6'd1);
  assign rb     = rtmp[0];
  assign mask   = (53'd1 << (sh - 6'd1)) - 53'd1;
  assign sticky = (nrm_i.mant & mask) != 53'd0;
  // nearest even; a carry into bit 52 lands on the smallest normal
  assign qr     = q + {52'd0, rb & (sticky | q[0])};

  always_comb begin
    item_d.shift = nrm_i.shift;
    if (nrm_i.pass) begin
      item_d.bits = nrm_i.bits;
    end else if (et >= ExpInf) begin
      item_d.bits = {sgn, ExpMax, 52'd0};
    end else if (et >= 13'sd1) begin
      item_d.bits = {sgn, et[10:0], nrm_i.mant[51:0]};
    end else if (sw >= ShiftZero) begin
      item_d.bits = {sgn, 63'd0};
    end else begin
      item_d.bits = {sgn, 10'd0, qr};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/double_scale_by_power_of_two_top.sv
// ------------------------------------------------------------------------
// double_scale_by_power_of_two_top
// binary64 times 2^shift, five rounded scaling steps in a 10-deep pipeline.
// ------------------------------------------------------------------------
//   channel | signals                                  | direction
//   in      | in_valid_i, in_ready_o, value_bits_i,    | request in
//           | exponent_shift_i                         |
//   out     | out_valid_o, out_ready_i, result_bits_o  | request out
//
// One request per cycle while the output is not stalled; a normalize and a
// round register per step, five steps cover a shift saturated to +/-4096.
// Whole pipeline holds while the output request waits; in_ready_o drops then.
// Reset clears only the valid bits.
// ------------------------------------------------------------------------
`include "double_scale_by_power_of_two_top_defines.svh"

module double_scale_by_power_of_two_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         value_bits_i,
  input  logic signed [31:0]  exponent_shift_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         result_bits_o
);
  import dblscl_pkg::*;

  logic                 en;
  item_t                itm [NumStages+1];
  nrm_t                 nrm [NumStages];
  logic [NumStages:0]   ivld;
  logic [NumStages-1:0] nvld;

  assign en = !ivld[NumStages] || out_ready_i;

  always_comb begin
    itm[0].bits = value_bits_i;
    if (exponent_shift_i > 32'sd4096) begin
      itm[0].shift = ShiftSat;
    end else if (exponent_shift_i < -32'sd4096) begin
      itm[0].shift = -ShiftSat;
    end else begin
      itm[0].shift = exponent_shift_i[13:0];
    end
  end
  assign ivld[0] = in_valid_i;

  for (genvar g = 0; g < NumStages; g++) begin : g_step
    dblscl_norm u_norm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ivld[g]),
      .item_i  (itm[g]),
      .valid_o (nvld[g]),
      .nrm_o   (nrm[g])
    );
    dblscl_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (nvld[g]),
      .nrm_i   (nrm[g]),
      .valid_o (ivld[g+1]),
      .item_o  (itm[g+1])
    );
  end

  assign in_ready_o    = en;
  assign out_valid_o   = ivld[NumStages];
  assign result_bits_o = itm[NumStages].bits;

  `DBLSCL_ASSERT_NEXT(a_hold_valids, clk_i, rst_ni, !en, $stable({ivld[NumStages:1], nvld}), "valid bits moved during stall")
  `DBLSCL_ASSERT_NEXT(a_last_advance, clk_i, rst_ni, en && nvld[NumStages-1], out_valid_o, "request lost in last step")
  `DBLSCL_ASSERT_NOW(a_nan_quiet, clk_i, rst_ni, out_valid_o && (result_bits_o[62:52] == ExpMax) && (result_bits_o[51:0] != 52'd0), result_bits_o[QuietBit], "signaling NaN on output")

endmodule

// File: tb/tb_double_scale_by_power_of_two_top.sv
// ------------------------------------------------------------------------
// tb_double_scale_by_power_of_two_top
// Self-checking bench for the binary64 power-of-two scaler: predicts each
// result with a staged, per-step rounded ldexp and checks the output queue.
// ------------------------------------------------------------------------
module tb_double_scale_by_power_of_two_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 30;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [63:0]        value_bits_i = '0;
  logic signed [31:0] exponent_shift_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [63:0]        result_bits_o;

  logic [63:0] scaled_q[$];
  int          fail_cnt = 0;
  bit          no_idle = 1'b0;

  double_scale_by_power_of_two_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_bits_i, .exponent_shift_i,
    .out_valid_o, .out_ready_i, .result_bits_o
  );

  always #6 clk_i = ~clk_i;

  // One rounded multiply by 2^k.
  function automatic logic [63:0] pow2_step(input logic [63:0] b, input int k);
    logic [63:0] sgn, m, q, rem, half;
    int          e, s;
    sgn = {b[63], 63'd0};
    m   = {12'd0, b[51:0]};
    if (b[62:52] == 11'h7FF) begin
      if (b[51:0] != 0) return b | (64'd1 << 51);
      return b;
    end
    if (b[62:0] == 0) return b;
    if (b[62:52] == 0) begin
      e = 1;
    end else begin
      e = int'(b[62:52]);
      m[52] = 1'b1;
    end
    while (m[52] == 1'b0) begin
      m = m << 1;
      e--;
    end
    e += k;
    if (e >= 2047) return sgn | {1'b0, 11'h7FF, 52'd0};
    if (e >= 1) return sgn | (64'(e) << 52) | {12'd0, m[51:0]};
    s = 1 - e;
    if (s >= 60) return sgn;
    q    = m >> s;
    rem  = m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return sgn | q;
  endfunction

  function automatic logic [63:0] ldexp_staged(input logic [63:0] b,
                                               input logic signed [31:0] sh);
    int n;
    n = sh;
    if (n > 4096) n = 4096;
    if (n < -4096) n = -4096;
    while (n > 1023) begin
      b = pow2_step(b, 1023);
      n -= 1023;
    end
    while (n < -1022) begin
      b = pow2_step(b, -1022);
      n += 1022;
    end
    return pow2_step(b, n);
  endfunction

  // valid stays up after acceptance until the next request or an idle cycle
  task automatic send_request(input logic [63:0] v, input logic signed [31:0] sh);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    value_bits_i     <= v;
    exponent_shift_i <= sh;
    scaled_q.push_back(ldexp_staged(v, sh));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= no_idle || ($urandom_range(99) >= 20);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scaled_q.size() == 0) begin
        $error("result_bits: no request pending, actual %h", result_bits_o);
        fail_cnt++;
      end else begin
        logic [63:0] exp_bits;
        exp_bits = scaled_q.pop_front();
        if (result_bits_o !== exp_bits) begin
          $error("result_bits: expected %h actual %h", exp_bits, result_bits_o);
          fail_cnt++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v[62:52] = 11'h000;
      1: v[62:52] = 11'h7FF;
      2: v[62:52] = 11'($urandom_range(3));
      3: v[62:52] = 11'h7FF - 11'($urandom_range(3));
      4: v[51:0]  = 52'd0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_shift();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(8400) - 4200;
      2: return $urandom_range(200) - 100;
      3: return $urandom_range(120) - 1140;
      default: return $urandom_range(2200) - 1100;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scaled_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_special_cases();
    send_request(64'h7FF0_0000_0000_0001, 5);          // signaling NaN
    send_request(64'hFFF8_0000_0000_1234, -7);         // quiet NaN
    send_request(64'h7FF0_0000_0000_0000, -5000);      // +inf
    send_request(64'hFFF0_0000_0000_0000, 3000);       // -inf
    send_request(64'h0000_0000_0000_0000, 4000);       // +0
    send_request(64'h8000_0000_0000_0000, -4000);      // -0
    send_request(64'h3FF0_0000_0000_0000, 1024);       // overflow
    send_request(64'hBFF0_0000_0000_0000, 1023);       // largest power
    send_request(64'h3FF0_0000_0000_0000, -1074);      // min subnormal
    send_request(64'h3FF8_0000_0000_0000, -1075);      // round up past half
    send_request(64'h3FF0_0000_0000_0000, -1075);      // tie to zero
    send_request(64'h0000_0000_0000_0001, 1074);       // subnormal up
    send_request(64'h7FEF_FFFF_FFFF_FFFF, -2098);      // double rounding
    send_request(64'h000F_FFFF_FFFF_FFFF, 1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
    send_request(64'h0010_0000_0000_0000, 32'sh8000_0000);
    send_request(64'h4000_0000_0000_0000, 4096);
    send_request(64'h4000_0000_0000_0000, 4097);
    send_request(64'h7FEF_FFFF_FFFF_FFFF, -4096);
    send_request(64'h3FF0_0000_0000_0000, 0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'sh5555_5555);
    send_request(64'h5555_5555_5555_5555, 32'shAAAA_AAAA);
  endtask

  task automatic test_random_requests();
    for (int i = 0; i < 850; i++) begin
      no_idle = (i >= 300 && i < 450);
      if (i == 600) wait_drained();
      send_request(rand_double(), rand_shift());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    wait_drained();
    test_random_requests();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && scaled_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
